>>> design/rv64x_pkg.sv
`timescale 1ns / 1ps
package rv64x_pkg;

  localparam int unsigned StoreWordsDefault = 8192;

  // operation codes
  typedef enum logic [5:0] {
    ACT_LUI, ACT_AUIPC, ACT_JAL, ACT_JALR,
    ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU,
    ACT_LB, ACT_LH, ACT_LW, ACT_LD, ACT_LBU, ACT_LHU, ACT_LWU,
    ACT_SB, ACT_SH, ACT_SW, ACT_SD,
    ACT_ADDI, ACT_SLTI, ACT_SLTIU, ACT_XORI, ACT_ORI, ACT_ANDI,
    ACT_SLLI, ACT_SRLI, ACT_SRAI,
    ACT_ADD, ACT_SUB, ACT_SLL, ACT_SLT, ACT_SLTU, ACT_XOR, ACT_SRL, ACT_SRA,
    ACT_OR, ACT_AND,
    ACT_ADDIW, ACT_SLLIW, ACT_SRLIW, ACT_SRAIW,
    ACT_ADDW, ACT_SUBW, ACT_SLLW, ACT_SRLW, ACT_SRAW,
    ACT_FENCE, ACT_ECALL, ACT_EBREAK, ACT_ILLEGAL
  } action_e;

  typedef struct packed {
    logic [5:0]         action;
    logic [63:0]        pc;
    logic [63:0]        first_operand;
    logic [63:0]        second_operand;
    logic signed [31:0] immediate;
    logic [15:0]        tag;
    logic               writes_dest;
  } in_word_t;

  typedef struct packed {
    logic [15:0] tag_out;
    logic        writes_dest_out;
    logic [63:0] result_value;
    logic        redirect_valid;
    logic [63:0] redirect_target;
    logic        redirect_is_trap;
  } out_word_t;

  // memory access request from the alu toward the load/store unit
  typedef struct packed {
    logic        is_load;
    logic        is_store;
    logic        is_signed;
    logic [3:0]  nbytes;
    logic [63:0] addr;
    logic [63:0] wdata;
  } mem_req_t;

endpackage

>>> design/rv64x_ram.sv
`timescale 1ns / 1ps
module rv64x_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rv64x_alu.sv
`timescale 1ns / 1ps
module rv64x_alu
  import rv64x_pkg::*;
(
  input  in_word_t  in_word_i,
  output out_word_t res_o,
  output mem_req_t  mem_o
);

  logic [63:0] a, b, imm, ea, link, btgt, val, tgt;
  logic        rv, trap, slt_ab, sltu_ab, take;
  logic [5:0]  shi, shr;
  logic [31:0] w;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  assign a    = in_word_i.first_operand;
  assign b    = in_word_i.second_operand;
  assign imm  = 64'(in_word_i.immediate);
  assign ea   = a + imm;
  assign link = in_word_i.pc + 64'd4;
  assign btgt = in_word_i.pc + imm;
  assign shi  = imm[5:0];
  assign shr  = b[5:0];
  assign slt_ab  = $signed(a) < $signed(b);
  assign sltu_ab = a < b;

  // result and redirect
  always_comb begin
    val  = '0;
    tgt  = '0;
    rv   = 1'b0;
    trap = 1'b0;
    take = 1'b0;
    w    = '0;
    case (action_e'(in_word_i.action))
      ACT_LUI:   val = imm;
      ACT_AUIPC: val = btgt;
      ACT_JAL: begin
        val = link; rv = 1'b1; tgt = btgt;
      end
      ACT_JALR: begin
        val = link; rv = 1'b1; tgt = {ea[63:1], 1'b0};
      end
      ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU: begin
        case (action_e'(in_word_i.action))
          ACT_BEQ:  take = (a == b);
          ACT_BNE:  take = (a != b);
          ACT_BLT:  take = slt_ab;
          ACT_BGE:  take = !slt_ab;
          ACT_BLTU: take = sltu_ab;
          default:  take = !sltu_ab;
        endcase
        rv  = 1'b1;
        tgt = take ? btgt : link;
      end
      ACT_ADDI:  val = ea;
      ACT_SLTI:  val = {63'd0, $signed(a) < $signed(imm)};
      ACT_SLTIU: val = {63'd0, a < imm};
      ACT_XORI:  val = a ^ imm;
      ACT_ORI:   val = a | imm;
      ACT_ANDI:  val = a & imm;
      ACT_SLLI:  val = a << shi;
      ACT_SRLI:  val = a >> shi;
      ACT_SRAI:  val = 64'($signed(a) >>> shi);
      ACT_ADD:   val = a + b;
      ACT_SUB:   val = a - b;
      ACT_SLL:   val = a << shr;
      ACT_SLT:   val = {63'd0, slt_ab};
      ACT_SLTU:  val = {63'd0, sltu_ab};
      ACT_XOR:   val = a ^ b;
      ACT_SRL:   val = a >> shr;
      ACT_SRA:   val = 64'($signed(a) >>> shr);
      ACT_OR:    val = a | b;
      ACT_AND:   val = a & b;
      ACT_ADDIW: val = sx32(ea[31:0]);
      ACT_SLLIW: begin w = a[31:0] << shi[4:0]; val = sx32(w); end
      ACT_SRLIW: begin w = a[31:0] >> shi[4:0]; val = sx32(w); end
      ACT_SRAIW: begin w = 32'($signed(a[31:0]) >>> shi[4:0]); val = sx32(w); end
      ACT_ADDW:  begin w = a[31:0] + b[31:0]; val = sx32(w); end
      ACT_SUBW:  begin w = a[31:0] - b[31:0]; val = sx32(w); end
      ACT_SLLW:  begin w = a[31:0] << shr[4:0]; val = sx32(w); end
      ACT_SRLW:  begin w = a[31:0] >> shr[4:0]; val = sx32(w); end
      ACT_SRAW:  begin w = 32'($signed(a[31:0]) >>> shr[4:0]); val = sx32(w); end
      ACT_ECALL, ACT_EBREAK: begin
        rv = 1'b1; trap = 1'b1; tgt = link;
      end
      default: ;
    endcase
  end

  // memory request decode
  always_comb begin
    mem_o.is_load   = 1'b0;
    mem_o.is_store  = 1'b0;
    mem_o.is_signed = 1'b0;
    mem_o.nbytes    = 4'd8;
    mem_o.addr      = ea;
    mem_o.wdata     = b;
    case (action_e'(in_word_i.action))
      ACT_LB:  begin mem_o.is_load = 1'b1; mem_o.is_signed = 1'b1; mem_o.nbytes = 4'd1; end
      ACT_LH:  begin mem_o.is_load = 1'b1; mem_o.is_signed = 1'b1; mem_o.nbytes = 4'd2; end
      ACT_LW:  begin mem_o.is_load = 1'b1; mem_o.is_signed = 1'b1; mem_o.nbytes = 4'd4; end
      ACT_LD:  mem_o.is_load = 1'b1;
      ACT_LBU: begin mem_o.is_load = 1'b1; mem_o.nbytes = 4'd1; end
      ACT_LHU: begin mem_o.is_load = 1'b1; mem_o.nbytes = 4'd2; end
      ACT_LWU: begin mem_o.is_load = 1'b1; mem_o.nbytes = 4'd4; end
      ACT_SB:  begin mem_o.is_store = 1'b1; mem_o.nbytes = 4'd1; end
      ACT_SH:  begin mem_o.is_store = 1'b1; mem_o.nbytes = 4'd2; end
      ACT_SW:  begin mem_o.is_store = 1'b1; mem_o.nbytes = 4'd4; end
      ACT_SD:  mem_o.is_store = 1'b1;
      default: ;
    endcase
  end

  assign res_o.tag_out          = in_word_i.tag;
  assign res_o.writes_dest_out  = in_word_i.writes_dest;
  assign res_o.result_value     = val;
  assign res_o.redirect_valid   = rv;
  assign res_o.redirect_target  = tgt;
  assign res_o.redirect_is_trap = trap;

endmodule

>>> design/rv64x_lsu.sv
`timescale 1ns / 1ps
module rv64x_lsu
  import rv64x_pkg::*;
#(
  parameter int unsigned StoreWords = StoreWordsDefault
) (
  input  logic        clk_i,
  input  logic        fire_i,
  input  mem_req_t    req_i,
  output logic [63:0] load_value_o
);

  localparam int unsigned Aw = $clog2(StoreWords);

  logic [7:0]    bank_en, bank_we;
  logic [Aw-1:0] bank_addr [8];
  logic [7:0]    bank_wdata [8];
  logic [7:0]    bank_rdata [8];
  logic [2:0]    off_q;
  logic [3:0]    nbytes_q;
  logic          sign_q;
  logic [63:0]   raw, ext;

  // one byte lane per bank; a wrapping access touches each lane at most once
  for (genvar k = 0; k < 8; k++) begin : g_bank
    logic [2:0]    idx;
    logic [Aw+2:0] sum;
    assign idx = 3'(3'(k) - req_i.addr[2:0]);
    assign sum = req_i.addr[Aw+2:0] + (Aw+3)'(idx);
    assign bank_addr[k]  = sum[Aw+2:3];
    assign bank_en[k]    = fire_i && (req_i.is_load || req_i.is_store) &&
                           ({1'b0, idx} < req_i.nbytes);
    assign bank_we[k]    = req_i.is_store;
    assign bank_wdata[k] = req_i.wdata[8*idx +: 8];

    rv64x_ram #(.Width(8), .Depth(StoreWords)) u_ram (
      .clk_i  (clk_i),
      .en_i   (bank_en[k]),
      .we_i   (bank_we[k]),
      .addr_i (bank_addr[k]),
      .wdata_i(bank_wdata[k]),
      .rdata_o(bank_rdata[k])
    );
  end

  // access shape, held until the data is consumed
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      off_q    <= req_i.addr[2:0];
      nbytes_q <= req_i.nbytes;
      sign_q   <= req_i.is_signed;
    end
  end

  // rotate lanes back into byte order
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      raw[8*j +: 8] = bank_rdata[3'(off_q + 3'(j))];
    end
  end

  // size and extension
  always_comb begin
    case (nbytes_q)
      4'd1:    ext = {{56{sign_q & raw[7]}}, raw[7:0]};
      4'd2:    ext = {{48{sign_q & raw[15]}}, raw[15:0]};
      4'd4:    ext = {{32{sign_q & raw[31]}}, raw[31:0]};
      default: ext = raw;
    endcase
  end

  assign load_value_o = ext;

endmodule

>>> design/rv64i_execute_unit.sv
`timescale 1ns / 1ps
// channel  valid        stall        word
// in       in_valid_i   in_stall_o   in_word_i  (in_word_t)
// out      out_valid_o  out_stall_i  out_word_o (out_word_t)
//
// one instruction per cycle unless stalled; the result passes through the execute and
// output registers; load data is a registered read of the byte-lane data store
// stores write at acceptance, so a following load sees them without forwarding
// reset clears only the valid flags; the data store is undefined until written
// out_stall_i backs up through the output and execute registers to in_stall_o
module rv64i_execute_unit
  import rv64x_pkg::*;
#(
  parameter int unsigned StoreWords = StoreWordsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  out_word_t   alu_res, s1_q, out_q, out_d;
  mem_req_t    mem_req;
  logic        s1_valid_q, out_valid_q, s1_load_q;
  logic        fire, s1_adv;
  logic [63:0] load_value;

  rv64x_alu u_alu (
    .in_word_i(in_word_i),
    .res_o    (alu_res),
    .mem_o    (mem_req)
  );

  rv64x_lsu #(.StoreWords(StoreWords)) u_lsu (
    .clk_i       (clk_i),
    .fire_i      (fire),
    .req_i       (mem_req),
    .load_value_o(load_value)
  );

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign fire       = in_valid_i && !in_stall_o;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= fire || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  // merge load data into the executed word
  always_comb begin
    out_d = s1_q;
    if (s1_load_q) begin
      out_d.result_value = load_value;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q      <= alu_res;
      s1_load_q <= mem_req.is_load;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced word did not reach output");

  a_trap_redirect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.redirect_is_trap) |-> out_word_o.redirect_valid)
    else $error("trap without redirect");

endmodule
